/* src/assert_macros.svh */
// Assertion macros shared by the hitbox collision checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcc assertion failed");

`endif

/* src/hcc_pkg.sv */
// Package with the constants, codes and types of the hitbox collision checker.
`timescale 1ns / 1ps

package hcc_pkg;

  localparam int BOX_DEPTH  = 64;
  localparam int RULE_DEPTH = 16;
  localparam int COORD_BITS = 16;
  localparam int TYPE_W     = 8;
  localparam int IDX_W      = 7;
  localparam int BOX_AW     = $clog2(BOX_DEPTH);
  localparam int BOX_CW     = $clog2(BOX_DEPTH + 1);
  localparam int RULE_CW    = $clog2(RULE_DEPTH + 1);
  localparam int SUM_W      = COORD_BITS + 2;
  localparam int IDX_CMP_W  = (IDX_W > BOX_CW) ? IDX_W : BOX_CW;

  typedef enum logic [1:0] {
    FN_ADD_BOX  = 2'd0,
    FN_ADD_RULE = 2'd1,
    FN_SET_POS  = 2'd2,
    FN_CHECK    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BOX_FULL  = 2'd1,
    ST_RULE_FULL = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_A,
    S_RD_B,
    S_PAIR,
    S_WAIT_RULE,
    S_CMP,
    S_FINISH
  } state_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] extent_t;
  typedef logic signed [SUM_W-1:0]      wide_coord_t;

  // One pair rule as held in a cell of the rule chain.
  typedef struct packed {
    logic [TYPE_W-1:0] first;
    logic [TYPE_W-1:0] second;
    logic              allow;
  } rule_t;

  // Lookup beat that travels down the rule chain, one cell per cycle.
  typedef struct packed {
    logic              vld;
    logic [TYPE_W-1:0] ta;
    logic [TYPE_W-1:0] tb;
    logic              done;
    logic              allow;
  } rule_tok_t;

endpackage

/* src/hcc_if.sv */
// Channel interfaces of the hitbox collision checker: operations, results, configuration.
`timescale 1ns / 1ps

interface hcc_in_if import hcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [TYPE_W-1:0] type_a;
  logic [TYPE_W-1:0] type_b;
  logic              can_collide;
  coord_t            pos_x;
  coord_t            pos_y;
  extent_t           box_width;
  extent_t           box_height;
  logic [IDX_W-1:0]  index_a;
  logic [IDX_W-1:0]  index_b;

  modport source (
    output valid, func, type_a, type_b, can_collide, pos_x, pos_y,
           box_width, box_height, index_a, index_b,
    input  ready
  );
  modport sink (
    input  valid, func, type_a, type_b, can_collide, pos_x, pos_y,
           box_width, box_height, index_a, index_b,
    output ready
  );
endinterface

interface hcc_out_if import hcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BOX_AW-1:0] new_index;
  logic              hit;
  status_t           status;

  modport source (output valid, new_index, hit, status, input ready);
  modport sink (input valid, new_index, hit, status, output ready);
endinterface

interface hcc_cfg_if ();
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* src/hitbox_collision_checker_unit.sv */
// Top level of the hitbox collision checker: control, hitbox memories and rule chain.
`timescale 1ns / 1ps
// Add hitbox, add rule and set position execute, then finish loads the result into the
// output register. A check ends at execute if an index is none or out of range; else both
// boxes are read, then allow_all_pairs sends the pair to the corner compare, equal types end
// it, and other pairs wait for the lookup beat to pass the rule chain. One item is in work at
// a time; the next is accepted once the result is in the output register. Reset (rst_n low,
// synchronous) empties both tables and clears allow_all_pairs; memories are not cleared.

`include "assert_macros.svh"

module hitbox_collision_checker_unit import hcc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  hcc_cfg_if.sink  cfg_ch,
  hcc_in_if.sink   in_ch,
  hcc_out_if.source out_ch
);

  // Shape and position live in separate memories so a move rewrites only position.
  typedef struct packed {
    logic [TYPE_W-1:0] btype;
    extent_t           wide;
    extent_t           tall;
  } shape_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
  } pos_t;

  state_t state_r;
  state_t state_nxt;

  logic allow_all_r;

  // Operation fields captured on the input beat.
  func_t             func_r;
  logic [TYPE_W-1:0] type_a_r;
  logic [TYPE_W-1:0] type_b_r;
  logic              can_collide_r;
  coord_t            pos_x_r;
  coord_t            pos_y_r;
  extent_t           width_r;
  extent_t           height_r;
  logic [IDX_W-1:0]  index_a_r;
  logic [IDX_W-1:0]  index_b_r;

  logic [BOX_CW-1:0]  box_count_r;
  logic [BOX_CW-1:0]  box_count_nxt;
  logic [RULE_CW-1:0] rule_count_r;
  logic [RULE_CW-1:0] rule_count_nxt;

  logic [BOX_AW-1:0] res_new_index_r;
  logic [BOX_AW-1:0] res_new_index_nxt;
  logic              res_hit_r;
  logic              res_hit_nxt;
  status_t           res_status_r;
  status_t           res_status_nxt;

  logic              out_vld_r;
  logic              out_vld_nxt;
  logic [BOX_AW-1:0] out_new_index_r;
  logic              out_hit_r;
  status_t           out_status_r;
  logic              out_load;

  shape_t shape_mem [BOX_DEPTH];
  pos_t   pos_mem   [BOX_DEPTH];
  shape_t rd_shape_r;
  pos_t   rd_pos_r;
  logic [BOX_AW-1:0] rd_addr;
  logic              shape_we;
  logic              pos_we;
  logic [BOX_AW-1:0] pos_waddr;

  shape_t a_shape_r;
  pos_t   a_pos_r;
  wide_coord_t a_right_r;
  wide_coord_t a_bot_r;
  wide_coord_t b_left_r;
  wide_coord_t b_top_r;
  wide_coord_t b_right_r;
  wide_coord_t b_bot_r;

  logic      rule_we;
  rule_t     wr_rule;
  logic      tok_launch;
  rule_tok_t tok_in;
  rule_tok_t tok_out;

  logic in_beat;
  logic box_full;
  logic rule_full;
  logic a_none;
  logic b_none;
  logic a_in_range;
  logic b_in_range;
  logic [BOX_AW-1:0] a_addr;
  logic [BOX_AW-1:0] b_addr;
  logic [BOX_AW-1:0] count_addr;
  wide_coord_t a_left_x;
  wide_coord_t a_top_x;
  logic x_any;
  logic y_any;

  // ---------------------------------------------------------------------------
  // Handshakes. Configuration is always taken; an operation only in idle.
  // ---------------------------------------------------------------------------
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_beat      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_all_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      allow_all_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      func_r        <= func_t'(in_ch.func);
      type_a_r      <= in_ch.type_a;
      type_b_r      <= in_ch.type_b;
      can_collide_r <= in_ch.can_collide;
      pos_x_r       <= in_ch.pos_x;
      pos_y_r       <= in_ch.pos_y;
      width_r       <= in_ch.box_width;
      height_r      <= in_ch.box_height;
      index_a_r     <= in_ch.index_a;
      index_b_r     <= in_ch.index_b;
    end
  end

  // ---------------------------------------------------------------------------
  // Index decode. All ones is the none index; any other negative value or one
  // at or above the hitbox count is out of range.
  // ---------------------------------------------------------------------------
  assign box_full   = (box_count_r >= BOX_CW'(BOX_DEPTH));
  assign rule_full  = (rule_count_r >= RULE_CW'(RULE_DEPTH));
  assign a_none     = (index_a_r == '1);
  assign b_none     = (index_b_r == '1);
  assign a_in_range = !index_a_r[IDX_W-1] &&
                      (IDX_CMP_W'(index_a_r[IDX_W-2:0]) < IDX_CMP_W'(box_count_r));
  assign b_in_range = !index_b_r[IDX_W-1] &&
                      (IDX_CMP_W'(index_b_r[IDX_W-2:0]) < IDX_CMP_W'(box_count_r));
  assign a_addr     = BOX_AW'(index_a_r[IDX_W-2:0]);
  assign b_addr     = BOX_AW'(index_b_r[IDX_W-2:0]);
  assign count_addr = BOX_AW'(box_count_r);

  // ---------------------------------------------------------------------------
  // Hitbox memories: one write and one registered read per cycle each.
  // ---------------------------------------------------------------------------
  assign rd_addr = (state_r == S_RD_A) ? a_addr : b_addr;

  always_ff @(posedge clk) begin
    if (shape_we) begin
      shape_mem[count_addr] <= '{btype: type_a_r, wide: width_r, tall: height_r};
    end
    rd_shape_r <= shape_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= '{left: pos_x_r, top: pos_y_r};
    end
    rd_pos_r <= pos_mem[rd_addr];
  end

  // Box A arrives while B is being read; B's edges are formed once B arrives.
  assign a_left_x = SUM_W'(a_pos_r.left);
  assign a_top_x  = SUM_W'(a_pos_r.top);

  always_ff @(posedge clk) begin
    if (state_r == S_RD_B) begin
      a_shape_r <= rd_shape_r;
      a_pos_r   <= rd_pos_r;
    end
    if (state_r == S_PAIR) begin
      a_right_r <= a_left_x + $signed({2'b00, a_shape_r.wide});
      a_bot_r   <= a_top_x + $signed({2'b00, a_shape_r.tall});
      b_left_r  <= SUM_W'(rd_pos_r.left);
      b_top_r   <= SUM_W'(rd_pos_r.top);
      b_right_r <= SUM_W'(rd_pos_r.left) + $signed({2'b00, rd_shape_r.wide});
      b_bot_r   <= SUM_W'(rd_pos_r.top) + $signed({2'b00, rd_shape_r.tall});
    end
  end

  // A corner of A lies inside B exactly when an x edge of A falls within B's
  // x span and a y edge of A falls within B's y span, bounds inclusive.
  assign x_any = (a_left_x >= b_left_r && a_left_x <= b_right_r) ||
                 (a_right_r >= b_left_r && a_right_r <= b_right_r);
  assign y_any = (a_top_x >= b_top_r && a_top_x <= b_bot_r) ||
                 (a_bot_r >= b_top_r && a_bot_r <= b_bot_r);

  // ---------------------------------------------------------------------------
  // Rule chain. A lookup beat passes through all cells in turn; the
  // first live cell whose rule matches fixes the verdict.
  // ---------------------------------------------------------------------------
  assign wr_rule = '{first: type_a_r, second: type_b_r, allow: can_collide_r};

  always_comb begin
    tok_in       = '0;
    tok_in.vld   = tok_launch;
    tok_in.ta    = a_shape_r.btype;
    tok_in.tb    = rd_shape_r.btype;
  end

  hcc_rule_chain u_rule_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (rule_we),
    .wr_rule    (wr_rule),
    .rule_count (rule_count_r),
    .tok_in     (tok_in),
    .tok_out    (tok_out)
  );

  // ---------------------------------------------------------------------------
  // Control sequencer.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      box_count_r  <= '0;
      rule_count_r <= '0;
    end else begin
      state_r      <= state_nxt;
      box_count_r  <= box_count_nxt;
      rule_count_r <= rule_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_new_index_r <= res_new_index_nxt;
    res_hit_r       <= res_hit_nxt;
    res_status_r    <= res_status_nxt;
  end

  always_comb begin
    state_nxt         = state_r;
    box_count_nxt     = box_count_r;
    rule_count_nxt    = rule_count_r;
    res_new_index_nxt = res_new_index_r;
    res_hit_nxt       = res_hit_r;
    res_status_nxt    = res_status_r;
    shape_we          = 1'b0;
    pos_we            = 1'b0;
    pos_waddr         = a_addr;
    rule_we           = 1'b0;
    tok_launch        = 1'b0;
    out_load          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_new_index_nxt = '0;
        res_hit_nxt       = 1'b0;
        res_status_nxt    = ST_OK;
        state_nxt         = S_FINISH;
        unique case (func_r)
          FN_ADD_BOX: begin
            if (box_full) begin
              res_status_nxt = ST_BOX_FULL;
            end else begin
              shape_we          = 1'b1;
              pos_we            = 1'b1;
              pos_waddr         = count_addr;
              res_new_index_nxt = count_addr;
              box_count_nxt     = box_count_r + 1'b1;
            end
          end
          FN_ADD_RULE: begin
            if (rule_full) begin
              res_status_nxt = ST_RULE_FULL;
            end else begin
              rule_we        = 1'b1;
              rule_count_nxt = rule_count_r + 1'b1;
            end
          end
          FN_SET_POS: begin
            if (!a_in_range) begin
              res_status_nxt = ST_BAD_INDEX;
            end else begin
              pos_we = 1'b1;
            end
          end
          FN_CHECK: begin
            // The none index wins over the range test.
            if (a_none || b_none) begin
              state_nxt = S_FINISH;
            end else if (!a_in_range || !b_in_range) begin
              res_status_nxt = ST_BAD_INDEX;
            end else begin
              state_nxt = S_RD_A;
            end
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_RD_A: begin
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        state_nxt = S_PAIR;
      end
      S_PAIR: begin
        if (allow_all_r) begin
          state_nxt = S_CMP;
        end else if (a_shape_r.btype == rd_shape_r.btype) begin
          state_nxt = S_FINISH;
        end else begin
          tok_launch = 1'b1;
          state_nxt  = S_WAIT_RULE;
        end
      end
      S_WAIT_RULE: begin
        if (tok_out.vld) begin
          state_nxt = (tok_out.done && tok_out.allow) ? S_CMP : S_FINISH;
        end
      end
      S_CMP: begin
        res_hit_nxt = x_any && y_any;
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        if (!out_vld_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register: a finished result waits here while the next item is taken.
  // ---------------------------------------------------------------------------
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_new_index_r <= res_new_index_r;
      out_hit_r       <= res_hit_r;
      out_status_r    <= res_status_r;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.new_index = out_new_index_r;
  assign out_ch.hit       = out_hit_r;
  assign out_ch.status    = out_status_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // A lookup beat leaves the chain only while the sequencer waits for it.
  `HCC_ASSERT_IMP(a_tok_only_in_wait, clk, rst_n, tok_out.vld, state_r == S_WAIT_RULE)
  // Every hitbox write advances the count by exactly one.
  `HCC_ASSERT_NEXT(a_box_count_step, clk, rst_n, shape_we, box_count_r == $past(box_count_r) + 1'b1)
  // A reported hit never carries an error status or a new index.
  `HCC_ASSERT_IMP(a_hit_clean, clk, rst_n, out_vld_r && out_hit_r, out_status_r == ST_OK && out_new_index_r == '0)

endmodule

/* src/hcc_rule_cell.sv */
// One cell of the rule chain: holds one pair rule and tests the passing lookup beat.
`timescale 1ns / 1ps

module hcc_rule_cell import hcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  rule_t     wr_rule,
  input  logic      live,
  input  rule_tok_t tok_in,
  output rule_tok_t tok_out
);

  rule_t     rule_r;
  rule_tok_t tok_r;
  rule_tok_t tok_nxt;
  logic      match;

  // A rule matches the two types in either order; only a live cell may decide.
  assign match = live &&
                 ((rule_r.first == tok_in.ta && rule_r.second == tok_in.tb) ||
                  (rule_r.first == tok_in.tb && rule_r.second == tok_in.ta));

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.vld && !tok_in.done && match) begin
      tok_nxt.done  = 1'b1;
      tok_nxt.allow = rule_r.allow;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_r <= wr_rule;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

/* src/hcc_rule_chain.sv */
// Row of rule cells; a lookup beat enters the first cell and leaves the last.
`timescale 1ns / 1ps

module hcc_rule_chain import hcc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  rule_t              wr_rule,
  input  logic [RULE_CW-1:0] rule_count,
  input  rule_tok_t          tok_in,
  output rule_tok_t          tok_out
);

  rule_tok_t tok [RULE_DEPTH+1];

  assign tok[0] = tok_in;

  // Rules are appended in order, so cell i holds rule i and is live below the count.
  for (genvar i = 0; i < RULE_DEPTH; i++) begin : g_cell
    hcc_rule_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (wr_en && (rule_count == RULE_CW'(i))),
      .wr_rule (wr_rule),
      .live    (RULE_CW'(i) < rule_count),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign tok_out = tok[RULE_DEPTH];

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the hitbox collision checker: directed and random operations.
`timescale 1ns / 1ps

module testbench;
  import hcc_pkg::*;

  // The run is ended here if the design hangs. This is far beyond the slowest legal run.
  localparam int TIMEOUT_NS  = 10_000_000;
  // Cycles allowed after the last result for any stray beat to show up.
  localparam int END_SLACK   = 40;
  // Length of the long receiver hold-off that fills the block and stalls its input.
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  localparam logic [IDX_W-1:0] NO_BOX  = '1;     // the "none" index, -1
  localparam logic [IDX_W-1:0] MOST_NEG = 7'h40; // -64, a negative index that is not none
  localparam coord_t  COORD_MIN  = 16'h8000;
  localparam coord_t  COORD_MAX  = 16'h7FFF;
  localparam extent_t EXTENT_MAX = 16'hFFFF;

  // One operation as offered on the input channel.
  typedef struct {
    func_t             func;
    logic [TYPE_W-1:0] type_a;
    logic [TYPE_W-1:0] type_b;
    logic              can_collide;
    coord_t            pos_x;
    coord_t            pos_y;
    extent_t           box_width;
    extent_t           box_height;
    logic [IDX_W-1:0]  index_a;
    logic [IDX_W-1:0]  index_b;
  } hitbox_op_t;

  // One beat on the result channel.
  typedef struct {
    logic [BOX_AW-1:0] new_index;
    logic              hit;
    status_t           status;
  } hitbox_result_t;

  logic clk;
  logic rst_n;

  hcc_cfg_if cfg_ch ();
  hcc_in_if  in_ch ();
  hcc_out_if out_ch ();

  hitbox_collision_checker_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Our own copy of the hitbox table, the rule table and the mode register.
  logic [TYPE_W-1:0] hb_type [BOX_DEPTH];
  int                hb_left [BOX_DEPTH];
  int                hb_top  [BOX_DEPTH];
  int                hb_wide [BOX_DEPTH];
  int                hb_tall [BOX_DEPTH];
  int                hb_total;
  logic [TYPE_W-1:0] rule_type_a [RULE_DEPTH];
  logic [TYPE_W-1:0] rule_type_b [RULE_DEPTH];
  logic              rule_verdict [RULE_DEPTH];
  int                rule_total;
  logic              allow_all_mode;

  // Results still owed by the block, oldest first.
  hitbox_result_t owed_results[$];
  int error_count;

  // Idle and stall rates in percent of cycles, set per phase by the test sequence.
  int send_idle_pct;
  int recv_stall_pct;

  // Long hold-off request: pulsed by the test sequence, counted down by the receiver.
  logic hold_req;
  int   hold_left;

  // Free-running clock, 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Safety net against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("testbench NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // True when the first rule naming the two types, in either order, lets them collide.
  // Equal types never collide, and a pair with no rule does not collide either.
  function automatic logic pair_may_collide(input logic [TYPE_W-1:0] ta,
                                            input logic [TYPE_W-1:0] tb);
    if (ta == tb) return 1'b0;
    for (int i = 0; i < rule_total; i++) begin
      if ((rule_type_a[i] == ta && rule_type_b[i] == tb) ||
          (rule_type_a[i] == tb && rule_type_b[i] == ta))
        return rule_verdict[i];
    end
    return 1'b0;
  endfunction

  // Inclusive point-in-rectangle test against hitbox b. All sums fit an int, so none wrap.
  function automatic logic corner_in_box(input int x, input int y, input int b);
    return x >= hb_left[b] && x <= hb_left[b] + hb_wide[b] &&
           y >= hb_top[b]  && y <= hb_top[b] + hb_tall[b];
  endfunction

  // Applies one accepted operation to the local tables and returns the result it must give.
  function automatic hitbox_result_t predict_result(input hitbox_op_t op);
    hitbox_result_t r;
    int ia;
    int ib;
    int x0;
    int y0;
    int x1;
    int y1;
    r.new_index = '0;
    r.hit       = 1'b0;
    r.status    = ST_OK;
    ia = $signed(op.index_a);
    ib = $signed(op.index_b);
    case (op.func)
      FN_ADD_BOX: begin
        if (hb_total >= BOX_DEPTH) begin
          r.status = ST_BOX_FULL;
        end else begin
          hb_type[hb_total] = op.type_a;
          hb_left[hb_total] = op.pos_x;
          hb_top[hb_total]  = op.pos_y;
          hb_wide[hb_total] = op.box_width;
          hb_tall[hb_total] = op.box_height;
          r.new_index = hb_total[BOX_AW-1:0];
          hb_total++;
        end
      end
      FN_ADD_RULE: begin
        if (rule_total >= RULE_DEPTH) begin
          r.status = ST_RULE_FULL;
        end else begin
          rule_type_a[rule_total]  = op.type_a;
          rule_type_b[rule_total]  = op.type_b;
          rule_verdict[rule_total] = op.can_collide;
          rule_total++;
        end
      end
      FN_SET_POS: begin
        if (ia < 0 || ia >= hb_total) begin
          r.status = ST_BAD_INDEX;
        end else begin
          hb_left[ia] = op.pos_x;
          hb_top[ia]  = op.pos_y;
        end
      end
      default: begin
        // The none index is tested before the range, so it never reports a bad index.
        if (ia == -1 || ib == -1) begin
          r.hit = 1'b0;
        end else if (ia < 0 || ib < 0 || ia >= hb_total || ib >= hb_total) begin
          r.status = ST_BAD_INDEX;
        end else if (allow_all_mode || pair_may_collide(hb_type[ia], hb_type[ib])) begin
          x0 = hb_left[ia];
          y0 = hb_top[ia];
          x1 = x0 + hb_wide[ia];
          y1 = y0 + hb_tall[ia];
          r.hit = corner_in_box(x0, y0, ib) || corner_in_box(x1, y0, ib) ||
                  corner_in_box(x0, y1, ib) || corner_in_box(x1, y1, ib);
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, the long hold-off, and the checker
  // ---------------------------------------------------------------------------

  initial out_ch.ready = 1'b0;

  // The hold-off counter lives here so that its length is counted in cycles, not by the test.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req) begin
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every result beat is matched against the oldest owed result, field by field.
  always @(posedge clk) begin
    hitbox_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (owed_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result beat with nothing owed: new_index=%0d hit=%0b status=%0d",
                   $realtime, out_ch.new_index, out_ch.hit, out_ch.status);
      end else begin
        want = owed_results.pop_front();
        if (out_ch.new_index !== want.new_index || out_ch.hit !== want.hit ||
            out_ch.status !== want.status) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: mismatch: expected new_index=%0d hit=%0b status=%0d, got %0d %0b %0d",
                     $realtime, want.new_index, want.hit, want.status,
                     out_ch.new_index, out_ch.hit, out_ch.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Operation side
  // ---------------------------------------------------------------------------

  // Offers one operation, with random idle cycles in front, and waits until it is taken.
  // Valid is left high afterwards so that back-to-back beats need no second assignment.
  task automatic send_op(input hitbox_op_t op);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= op.func;
    in_ch.type_a      <= op.type_a;
    in_ch.type_b      <= op.type_b;
    in_ch.can_collide <= op.can_collide;
    in_ch.pos_x       <= op.pos_x;
    in_ch.pos_y       <= op.pos_y;
    in_ch.box_width   <= op.box_width;
    in_ch.box_height  <= op.box_height;
    in_ch.index_a     <= op.index_a;
    in_ch.index_b     <= op.index_b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    owed_results = {owed_results, predict_result(op)};
  endtask

  // A fully random operation. Fields the operation does not use still toggle this way.
  function automatic hitbox_op_t random_noise_op();
    hitbox_op_t op;
    op.func        = func_t'($urandom_range(3));
    op.type_a      = TYPE_W'($urandom_range(255));
    op.type_b      = TYPE_W'($urandom_range(255));
    op.can_collide = 1'($urandom_range(1));
    op.pos_x       = coord_t'($urandom_range(65535));
    op.pos_y       = coord_t'($urandom_range(65535));
    op.box_width   = extent_t'($urandom_range(65535));
    op.box_height  = extent_t'($urandom_range(65535));
    op.index_a     = IDX_W'($urandom_range(127));
    op.index_b     = IDX_W'($urandom_range(127));
    return op;
  endfunction

  task automatic add_box(input logic [TYPE_W-1:0] t, input coord_t x, input coord_t y,
                         input extent_t w, input extent_t h);
    hitbox_op_t op;
    op = random_noise_op();
    op.func       = FN_ADD_BOX;
    op.type_a     = t;
    op.pos_x      = x;
    op.pos_y      = y;
    op.box_width  = w;
    op.box_height = h;
    send_op(op);
  endtask

  task automatic add_rule(input logic [TYPE_W-1:0] ta, input logic [TYPE_W-1:0] tb,
                          input logic verdict);
    hitbox_op_t op;
    op = random_noise_op();
    op.func        = FN_ADD_RULE;
    op.type_a      = ta;
    op.type_b      = tb;
    op.can_collide = verdict;
    send_op(op);
  endtask

  task automatic move_box(input logic [IDX_W-1:0] idx, input coord_t x, input coord_t y);
    hitbox_op_t op;
    op = random_noise_op();
    op.func    = FN_SET_POS;
    op.index_a = idx;
    op.pos_x   = x;
    op.pos_y   = y;
    send_op(op);
  endtask

  task automatic check_pair(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b);
    hitbox_op_t op;
    op = random_noise_op();
    op.func    = FN_CHECK;
    op.index_a = a;
    op.index_b = b;
    send_op(op);
  endtask

  // Coordinates and sizes cluster in a small window so that boxes overlap often,
  // with the full range mixed in now and then.
  function automatic coord_t random_coord();
    int v;
    if ($urandom_range(99) < 85) v = int'($urandom_range(400)) - 200;
    else v = int'($urandom_range(65535));
    return coord_t'(v);
  endfunction

  function automatic extent_t random_extent();
    if ($urandom_range(99) < 85) return extent_t'($urandom_range(120));
    return extent_t'($urandom_range(65535));
  endfunction

  // A few types dominate so that rules actually match the boxes being checked.
  function automatic logic [TYPE_W-1:0] random_type();
    if ($urandom_range(99) < 90) return TYPE_W'($urandom_range(5));
    return TYPE_W'($urandom_range(255));
  endfunction

  // Mostly an index of a box that exists; sometimes none, sometimes anything at all.
  function automatic logic [IDX_W-1:0] pick_index();
    int roll;
    roll = $urandom_range(99);
    if (hb_total > 0 && roll < 85) return IDX_W'($urandom_range(hb_total - 1));
    if (roll < 90) return NO_BOX;
    return IDX_W'($urandom_range(127));
  endfunction

  // Drops valid and waits until every owed result has come back, so the block is idle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // Writes the allow-all-pairs register. Only called while the block is idle.
  task automatic write_allow_all(input logic value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid   <= 1'b0;
    allow_all_mode = value;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Before any box exists: none indices, out-of-range indices and a move of nothing.
  task automatic test_empty_table();
    check_pair(NO_BOX, NO_BOX);
    check_pair(7'd0, 7'd0);
    check_pair(MOST_NEG, 7'd0);
    move_box(7'd0, 16'sd5, 16'sd5);
  endtask

  // Boxes at both ends of the coordinate range, the largest and the empty size,
  // and a few small ones used by the checks below.
  task automatic test_add_extremes();
    add_box(8'd0, COORD_MIN, COORD_MIN, EXTENT_MAX, EXTENT_MAX);   // box 0
    add_box(8'd255, COORD_MAX, COORD_MAX, 16'd0, 16'd0);           // box 1
    add_box(8'd1, 16'sd0, 16'sd0, 16'd10, 16'd10);                 // box 2
    add_box(8'd2, 16'sd10, 16'sd10, 16'd5, 16'd5);                 // box 3
    add_box(8'd1, 16'sd100, 16'sd100, 16'd3, 16'd3);               // box 4
  endtask

  // The second rule for types 1 and 2 is shadowed by the first one.
  task automatic test_rules();
    add_rule(8'd1, 8'd2, 1'b1);
    add_rule(8'd255, 8'd0, 1'b1);
    add_rule(8'd2, 8'd1, 1'b0);
    add_rule(8'd2, 8'd3, 1'b0);
  endtask

  task automatic test_checks();
    check_pair(7'd2, 7'd3);    // corners touch exactly: inclusive bounds give a hit
    check_pair(7'd3, 7'd2);    // same rule found in the other order
    check_pair(7'd2, 7'd4);    // equal types
    check_pair(7'd0, 7'd1);    // extreme corner of the huge box lands on the empty box
    check_pair(7'd1, 7'd0);
    check_pair(7'd2, 7'd0);    // no rule for types 1 and 0
    check_pair(7'd2, NO_BOX);
    check_pair(7'd63, 7'd2);   // index beyond the boxes added so far
  endtask

  task automatic test_moves();
    move_box(7'd4, 16'sd8, 16'sd8);
    check_pair(7'd4, 7'd3);    // moved box now overlaps box 3
    move_box(NO_BOX, 16'sd0, 16'sd0);
    move_box(7'd63, 16'sd0, 16'sd0);
  endtask

  // Mostly well-formed operations on existing boxes, with some fully random noise.
  task automatic test_random_ops(input int count);
    int roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 15)
        add_box(random_type(), random_coord(), random_coord(), random_extent(), random_extent());
      else if (roll < 18)
        add_rule(random_type(), random_type(), 1'($urandom_range(1)));
      else if (roll < 40)
        move_box(pick_index(), random_coord(), random_coord());
      else if (roll < 97)
        check_pair(pick_index(), pick_index());
      else
        send_op(random_noise_op());
    end
  endtask

  // The receiver holds off for a long stretch while operations keep coming, so the
  // block fills up and must stall its input.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    test_random_ops(30);
  endtask

  // Fill both tables if the random part has not, then go past the end of each.
  task automatic test_table_limits();
    while (hb_total < BOX_DEPTH)
      add_box(random_type(), random_coord(), random_coord(), random_extent(), random_extent());
    repeat (2) add_box(random_type(), random_coord(), random_coord(), 16'd1, 16'd1);
    while (rule_total < RULE_DEPTH)
      add_rule(random_type(), random_type(), 1'($urandom_range(1)));
    repeat (2) add_rule(random_type(), random_type(), 1'($urandom_range(1)));
    check_pair(7'd63, 7'd62);
    check_pair(7'd62, 7'd63);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Every input gets a known value before the first edge.
    rst_n             = 1'b0;
    hold_req          = 1'b0;
    hold_left         = 0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FN_ADD_BOX;
    in_ch.type_a      = '0;
    in_ch.type_b      = '0;
    in_ch.can_collide = 1'b0;
    in_ch.pos_x       = '0;
    in_ch.pos_y       = '0;
    in_ch.box_width   = '0;
    in_ch.box_height  = '0;
    in_ch.index_a     = '0;
    in_ch.index_b     = '0;
    hb_total          = 0;
    rule_total        = 0;
    allow_all_mode    = 1'b0;
    error_count       = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the mode register at its reset value written explicitly.
    write_allow_all(1'b0);
    test_empty_table();
    test_add_extremes();
    test_rules();
    test_checks();
    test_moves();
    drain_results();

    // Random phases. The mode flips between phases, always with the block idle.
    test_random_ops(300);
    drain_results();

    write_allow_all(1'b1);
    send_idle_pct = 57;
    test_random_ops(300);
    drain_results();

    write_allow_all(1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 57;
    test_random_ops(300);
    drain_results();

    write_allow_all(1'b1);
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    test_random_ops(300);
    drain_results();

    write_allow_all(1'b0);
    test_backpressure();
    drain_results();

    send_idle_pct  = 23;
    recv_stall_pct = 23;
    test_table_limits();
    drain_results();

    // Give any stray result beat time to appear before the verdict.
    repeat (END_SLACK) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
